// ----- rtl/gnt_pkg.sv -----
// Shared types and constants for the gradient noise / turbulence block.
// No dependencies.
`default_nettype none
package gnt_pkg;

	localparam int TABLE_SIZE_DEF  = 256;
	localparam int MAX_OCTAVES_DEF = 8;
	localparam int FRAC_BITS_DEF   = 16;

	localparam int S_TDATA_W = 160;
	localparam int S_TUSER_W = 4;
	localparam int M_TDATA_W = 24;
	localparam int NOISE_W   = 21;

	localparam logic [1:0] KIND_PERM = 2'd0;
	localparam logic [1:0] KIND_GRAD = 2'd1;
	localparam logic [1:0] KIND_EVAL = 2'd2;

	localparam logic [1:0] SEL_X = 2'd0;
	localparam logic [1:0] SEL_Y = 2'd1;
	localparam logic [1:0] SEL_Z = 2'd2;

	localparam logic REG_OCTAVE_COUNT   = 1'b0;
	localparam logic REG_TURBULENCE_MODE = 1'b1;

	localparam logic [3:0] OCTAVE_COUNT_RST = 4'd7;
	localparam logic       TURB_MODE_RST    = 1'b1;

	typedef struct packed {
		logic       valid;
		logic [2:0] corner;  // {x, y, z} lattice offsets
	} corner_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/gnt_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module gnt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/gnt_corner.sv -----
// Corner datapath: gradient dot product and trilinear weighting, one corner per cycle.
// Depends on gnt_pkg.
`default_nettype none
module gnt_corner #(
	parameter int FRAC_BITS = gnt_pkg::FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire gnt_pkg::corner_ctl_t  ctl_s2,
	input  wire logic [47:0]           grad_s2,
	input  wire logic [FRAC_BITS-1:0]  frac [3],
	input  wire logic [FRAC_BITS:0]    fade [3],
	output logic                       corner_valid,
	output logic signed [FRAC_BITS+4:0] corner_val
);

	localparam int FB = FRAC_BITS;
	localparam int DW = FB + 5;
	localparam int PRW = FB + 18;
	localparam int SUMW = FB + 20;
	localparam int MW = DW + FB + 2;

	gnt_pkg::corner_ctl_t ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7;

	logic signed [PRW-1:0]  prod [3];
	logic signed [PRW-1:0]  prod_s3 [3];
	logic signed [SUMW-1:0] dot_sum;
	logic signed [DW-1:0]   d_s4, c_s5, c_s6, c_s7;
	logic signed [MW-1:0]   m5, m6, m7;
	logic signed [FB+1:0]   w5, w6, w7;

	function automatic logic signed [FB+1:0] weight(input logic hi, input logic [FB:0] f);
		logic [FB+1:0] one;
		one = (FB+2)'(1) << FB;
		return hi ? $signed({1'b0, f}) : $signed(one - {1'b0, f});
	endfunction

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			prod[a] = PRW'($signed(grad_s2[16*a +: 16]) *
				($signed({2'b00, frac[a]}) -
				 (ctl_s2.corner[2-a] ? $signed((FB+2)'(1) << FB) : $signed((FB+2)'(0)))));
		end
		dot_sum = SUMW'(prod_s3[0]) + SUMW'(prod_s3[1]) + SUMW'(prod_s3[2]);
		w5 = weight(ctl_s4.corner[2], fade[0]);
		w6 = weight(ctl_s5.corner[1], fade[1]);
		w7 = weight(ctl_s6.corner[0], fade[2]);
		m5 = MW'(d_s4) * MW'(w5);
		m6 = MW'(c_s5) * MW'(w6);
		m7 = MW'(c_s6) * MW'(w7);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
		end else begin
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
		end
	end

	always_ff @(posedge clk) begin
		prod_s3 <= prod;
		d_s4    <= DW'(dot_sum >>> 15);
		c_s5    <= DW'(m5 >>> FB);
		c_s6    <= DW'(m6 >>> FB);
		c_s7    <= DW'(m7 >>> FB);
	end

	assign corner_valid = ctl_s7.valid;
	assign corner_val   = c_s7;

endmodule
`default_nettype wire

// ----- rtl/gradient_noise_turbulence_top.sv -----
// Top level of the 3D gradient noise / turbulence block.
// Depends on gnt_pkg, gnt_ram and gnt_corner.
//
// Input channel s_*: tuser carries kind and table select, tdata the payload.
// Kind 0 writes one permutation entry, kind 1 one gradient entry; neither gives a
// result. Kind 2 evaluates a point and gives one result item on m_*.
// Configuration is written through cfg_we / cfg_index / cfg_data.
// An evaluation runs octave by octave: fade arithmetic in ST_FADE1 and ST_FADE2,
// eight corner lookups issued one per cycle from the permutation RAMs and then the
// gradient RAM, a wait in ST_WAIT for the corner pipeline to drain, and an add into
// the turbulence sum in ST_ACCUM (n octaves, one in plain mode). After the last
// octave ST_FIN registers the result; the next item is taken in ST_IDLE only.
// The serial corner issue bounds the rate.
// A new item is accepted once the previous evaluation has reached the output
// register, even if that result is still waiting; a stalled receiver holds
// the result and blocks only the next evaluation from finishing.
// Reset clears control state and restores octave_count 7, turbulence mode on;
// table contents are undefined until loaded.
`default_nettype none
module gradient_noise_turbulence_top #(
	parameter int TABLE_SIZE  = gnt_pkg::TABLE_SIZE_DEF,
	parameter int MAX_OCTAVES = gnt_pkg::MAX_OCTAVES_DEF,
	parameter int FRAC_BITS   = gnt_pkg::FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// entry_index, perm_value, grad_x, grad_y, grad_z, pos_x, pos_y, pos_z
	input  wire logic [gnt_pkg::S_TDATA_W-1:0] s_tdata,
	// kind, table_select
	input  wire logic [gnt_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// noise_value, zero padding
	output logic [gnt_pkg::M_TDATA_W-1:0]      m_tdata,
	input  wire logic                          cfg_we,
	input  wire logic [0:0]                    cfg_index,
	input  wire logic [3:0]                    cfg_data
);

	localparam int IW   = $clog2(TABLE_SIZE);
	localparam int FB   = FRAC_BITS;
	localparam int PW   = (FB + IW > 32) ? FB + IW : 32;
	localparam int DW   = FB + 5;
	localparam int OW   = DW + 3;
	localparam int SW   = OW + 2;
	localparam int RW   = SW + 8;
	localparam int OCW  = $clog2(MAX_OCTAVES + 1);
	localparam int SH_R = (FB >= 16) ? FB - 16 : 0;
	localparam int SH_L = (FB < 16) ? 16 - FB : 0;
	localparam int NW   = gnt_pkg::NOISE_W;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_FADE1 = 7'b0000010,
		ST_FADE2 = 7'b0000100,
		ST_ISSUE = 7'b0001000,
		ST_WAIT  = 7'b0010000,
		ST_ACCUM = 7'b0100000,
		ST_FIN   = 7'b1000000
	} state_t;

	state_t st_q;

	logic [1:0]  kind, sel;
	logic        acc;
	logic [IW-1:0] widx;

	assign kind = s_tuser[1:0];
	assign sel  = s_tuser[3:2];
	assign s_tready = (st_q == ST_IDLE);
	assign acc  = s_tvalid && s_tready;
	assign widx = IW'(s_tdata[7:0]);

	logic [3:0] octave_count_q;
	logic       turb_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_count_q <= gnt_pkg::OCTAVE_COUNT_RST;
			turb_mode_q    <= gnt_pkg::TURB_MODE_RST;
		end else if (cfg_we) begin
			case (cfg_index[0])
				gnt_pkg::REG_OCTAVE_COUNT:    octave_count_q <= cfg_data;
				gnt_pkg::REG_TURBULENCE_MODE: turb_mode_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic [PW-1:0]   pos_q [3];
	logic [OCW-1:0]  n_q, o_q, n_turb;
	logic            turb_q;
	logic [2:0]      corner_q;
	logic [3:0]      acc_cnt_q;
	logic signed [OW-1:0] oct_q;
	logic signed [SW-1:0] sum_q;
	logic [FB-1:0]   sq_q [3];
	logic [FB:0]     fade_q [3];
	logic [FB-1:0]   frac [3];
	logic [IW-1:0]   lat [3];
	logic [2*FB-1:0] sq_full [3];
	logic [2*FB+1:0] fade_full [3];
	logic            issue;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			frac[a] = pos_q[a][FB-1:0];
			lat[a] = pos_q[a][FB +: IW];
			sq_full[a] = (2*FB)'(frac[a]) * (2*FB)'(frac[a]);
			fade_full[a] = (2*FB+2)'(sq_q[a]) *
				(2*FB+2)'(((FB+2)'(3) << FB) - (FB+2)'({frac[a], 1'b0}));
		end
		if ({1'b0, octave_count_q} > 5'(MAX_OCTAVES)) begin
			n_turb = OCW'(MAX_OCTAVES);
		end else begin
			n_turb = OCW'(octave_count_q);
		end
	end

	assign issue = (st_q == ST_ISSUE);

	// table memories
	logic [7:0]  px_s1, py_s1, pz_s1;
	logic [47:0] grad_s2;
	logic [IW-1:0] hash_s1;

	assign hash_s1 = IW'(px_s1 ^ py_s1 ^ pz_s1);

	gnt_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_perm_x (
		.clk(clk),
		.we(acc && kind == gnt_pkg::KIND_PERM && sel == gnt_pkg::SEL_X),
		.waddr(widx), .wdata(s_tdata[15:8]),
		.raddr(lat[0] + IW'(corner_q[2])), .rdata(px_s1)
	);

	gnt_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_perm_y (
		.clk(clk),
		.we(acc && kind == gnt_pkg::KIND_PERM && sel == gnt_pkg::SEL_Y),
		.waddr(widx), .wdata(s_tdata[15:8]),
		.raddr(lat[1] + IW'(corner_q[1])), .rdata(py_s1)
	);

	gnt_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_perm_z (
		.clk(clk),
		.we(acc && kind == gnt_pkg::KIND_PERM && sel == gnt_pkg::SEL_Z),
		.waddr(widx), .wdata(s_tdata[15:8]),
		.raddr(lat[2] + IW'(corner_q[0])), .rdata(pz_s1)
	);

	gnt_ram #(.WIDTH(48), .DEPTH(TABLE_SIZE)) u_grad (
		.clk(clk),
		.we(acc && kind == gnt_pkg::KIND_GRAD),
		.waddr(widx), .wdata(s_tdata[63:16]),
		.raddr(hash_s1), .rdata(grad_s2)
	);

	gnt_pkg::corner_ctl_t ctl_s1, ctl_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= '{valid: issue, corner: corner_q};
			ctl_s2 <= ctl_s1;
		end
	end

	logic                 cv;
	logic signed [DW-1:0] cval;

	gnt_corner #(.FRAC_BITS(FB)) u_corner (
		.clk(clk), .arst_n(arst_n),
		.ctl_s2(ctl_s2), .grad_s2(grad_s2),
		.frac(frac), .fade(fade_q),
		.corner_valid(cv), .corner_val(cval)
	);

	// result formatting
	logic signed [SW-1:0] mag;
	logic signed [RW-1:0] res_w;
	logic [NW-1:0]        res;

	always_comb begin
		mag   = (turb_q && sum_q < 0) ? -sum_q : sum_q;
		res_w = (RW'(mag) <<< SH_L) >>> SH_R;
		if (res_w > $signed(RW'((1 << (NW-1)) - 1))) begin
			res = NW'((1 << (NW-1)) - 1);
		end else if (res_w < -$signed(RW'(1 << (NW-1)))) begin
			res = NW'(1 << (NW-1));
		end else begin
			res = NW'(res_w);
		end
	end

	logic          m_valid_q;
	logic [NW-1:0] noise_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			m_valid_q <= 1'b0;
			corner_q  <= '0;
			acc_cnt_q <= '0;
			o_q       <= '0;
			n_q       <= '0;
			turb_q    <= 1'b0;
		end else begin
			if (m_valid_q && m_tready && st_q != ST_FIN) begin
				m_valid_q <= 1'b0;
			end
			if (cv) begin
				acc_cnt_q <= acc_cnt_q + 4'd1;
			end
			case (st_q)
				ST_IDLE: begin
					if (acc && kind == gnt_pkg::KIND_EVAL) begin
						turb_q <= turb_mode_q;
						n_q    <= turb_mode_q ? n_turb : OCW'(1);
						o_q    <= '0;
						if (turb_mode_q && n_turb == '0) begin
							st_q <= ST_FIN;
						end else begin
							st_q <= ST_FADE1;
						end
					end
				end
				ST_FADE1: begin
					corner_q  <= '0;
					acc_cnt_q <= '0;
					st_q      <= ST_FADE2;
				end
				ST_FADE2: st_q <= ST_ISSUE;
				ST_ISSUE: begin
					corner_q <= corner_q + 3'd1;
					if (corner_q == 3'd7) begin
						st_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (acc_cnt_q == 4'd8) begin
						st_q <= ST_ACCUM;
					end
				end
				ST_ACCUM: begin
					o_q <= o_q + OCW'(1);
					if (o_q + OCW'(1) == n_q) begin
						st_q <= ST_FIN;
					end else begin
						st_q <= ST_FADE1;
					end
				end
				ST_FIN: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						st_q      <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				pos_q[0] <= PW'($signed(s_tdata[95:64]));
				pos_q[1] <= PW'($signed(s_tdata[127:96]));
				pos_q[2] <= PW'($signed(s_tdata[159:128]));
				sum_q    <= '0;
			end
			ST_FADE1: begin
				for (int a = 0; a < 3; a++) begin
					sq_q[a] <= FB'(sq_full[a] >> FB);
				end
				oct_q <= '0;
			end
			ST_FADE2: begin
				for (int a = 0; a < 3; a++) begin
					fade_q[a] <= (FB+1)'(fade_full[a] >> FB);
				end
			end
			ST_ACCUM: begin
				sum_q <= sum_q + SW'(oct_q >>> o_q);
				for (int a = 0; a < 3; a++) begin
					pos_q[a] <= pos_q[a] << 1;
				end
			end
			ST_FIN: begin
				if (!m_valid_q || m_tready) begin
					noise_q <= res;
				end
			end
			default: ;
		endcase
		if (cv) begin
			oct_q <= oct_q + OW'(cval);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = gnt_pkg::M_TDATA_W'(noise_q);

endmodule
`default_nettype wire

// ----- rtl/gnt_chk.sv -----
// Port-level checker for the gradient noise block, bound to the top level.
// Depends on gnt_pkg and gradient_noise_turbulence_top.
`default_nettype none
module gnt_chk (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tvalid,
	input wire logic                          s_tready,
	input wire logic [gnt_pkg::S_TUSER_W-1:0] s_tuser,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [gnt_pkg::M_TDATA_W-1:0] m_tdata
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[gnt_pkg::M_TDATA_W-1:gnt_pkg::NOISE_W] == '0)
		else $error("padding bits set");

	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[1:0] == gnt_pkg::KIND_EVAL |=> !s_tready)
		else $error("item taken during evaluation");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[1:0] != gnt_pkg::KIND_EVAL && !m_tvalid
		|=> !m_tvalid)
		else $error("result from a non-evaluate item");

endmodule

bind gradient_noise_turbulence_top gnt_chk u_gnt_chk (
	.clk(clk), .arst_n(arst_n),
	.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

// ----- tb/sv/gradient_noise_turbulence_top_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for gradient_noise_turbulence_top: table loads, point
// evaluations and register settings are checked against an in-bench noise predictor.
// Depends on gnt_pkg and the block's RTL only.
module gradient_noise_turbulence_top_tb;
	import gnt_pkg::*;

	typedef struct {
		logic [1:0]         kind;
		logic [1:0]         sel;
		logic [7:0]         idx;
		logic [7:0]         pval;
		logic signed [15:0] gx, gy, gz;
		logic signed [31:0] px, py, pz;
	} noise_item_t;

	typedef struct {
		noise_item_t        it;
		bit                 typed;
		logic signed [20:0] val;
	} dir_row_t;

	localparam int N_DIR = 20;
	localparam longint ONE = 64'sd65536;
	localparam int HOLD_CYCLES = 3000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;  // entry_index, perm_value, grad_x/y/z, pos_x/y/z
	logic [S_TUSER_W-1:0]  s_tuser;  // kind, table_select
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;  // noise_value, zero padding
	logic                  cfg_we;
	logic [0:0]            cfg_index;
	logic [3:0]            cfg_data;

	logic [7:0]          perm_x [256];
	logic [7:0]          perm_y [256];
	logic [7:0]          perm_z [256];
	logic signed [15:0]  grad_tab [256][3];
	logic [3:0]          octaves;
	logic                turb_on;

	logic signed [20:0]  noise_expect_q [$];
	dir_row_t            dir_rows [N_DIR];
	int                  errors;
	int                  results_seen;
	int                  evals_sent;
	int                  burst_left;
	bit                  long_hold;

	gradient_noise_turbulence_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	function automatic longint smooth(longint u);
		longint sq;
		sq = (u * u) >>> 16;
		return (sq * (3 * ONE - 2 * u)) >>> 16;
	endfunction

	function automatic longint octave_sum(longint unsigned p [3]);
		longint unsigned lat [3];
		longint frac [3];
		longint w [3][2];
		longint acc, dot, c;
		logic [7:0] h;
		acc = 0;
		for (int a = 0; a < 3; a++) begin
			lat[a] = p[a] >> 16;
			frac[a] = longint'(p[a] & 64'hFFFF);
			w[a][1] = smooth(frac[a]);
			w[a][0] = ONE - w[a][1];
		end
		for (int i = 0; i < 2; i++)
			for (int j = 0; j < 2; j++)
				for (int k = 0; k < 2; k++) begin
					h = perm_x[8'(lat[0] + i)] ^ perm_y[8'(lat[1] + j)]
						^ perm_z[8'(lat[2] + k)];
					dot = longint'(grad_tab[h][0]) * (frac[0] - i * ONE)
						+ longint'(grad_tab[h][1]) * (frac[1] - j * ONE)
						+ longint'(grad_tab[h][2]) * (frac[2] - k * ONE);
					c = dot >>> 15;
					c = (c * w[0][i]) >>> 16;
					c = (c * w[1][j]) >>> 16;
					c = (c * w[2][k]) >>> 16;
					acc += c;
				end
		return acc;
	endfunction

	function automatic logic signed [20:0] predict_noise(noise_item_t it);
		longint unsigned p [3];
		longint sum;
		int n;
		p[0] = longint'(it.px);
		p[1] = longint'(it.py);
		p[2] = longint'(it.pz);
		sum = 0;
		if (turb_on) begin
			n = (octaves > 8) ? 8 : octaves;
			for (int o = 0; o < n; o++) begin
				sum += octave_sum(p) >>> o;
				for (int a = 0; a < 3; a++) p[a] = p[a] << 1;
			end
			if (sum < 0) sum = -sum;
		end else begin
			sum = octave_sum(p);
		end
		if (sum > 1048575) sum = 1048575;
		if (sum < -1048576) sum = -1048576;
		return 21'(sum);
	endfunction

	task automatic send_item(noise_item_t it, bit typed, logic signed [20:0] val);
		s_tdata <= {it.pz, it.py, it.px, it.gz, it.gy, it.gx, it.pval, it.idx};
		s_tuser <= {it.sel, it.kind};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		case (it.kind)
			KIND_PERM: begin
				if (it.sel == SEL_X) perm_x[it.idx] = it.pval;
				else if (it.sel == SEL_Y) perm_y[it.idx] = it.pval;
				else if (it.sel == SEL_Z) perm_z[it.idx] = it.pval;
			end
			KIND_GRAD: begin
				grad_tab[it.idx][0] = it.gx;
				grad_tab[it.idx][1] = it.gy;
				grad_tab[it.idx][2] = it.gz;
			end
			KIND_EVAL: begin
				noise_expect_q.push_back(typed ? val : predict_noise(it));
				evals_sent++;
			end
			default: ;
		endcase
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 2) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	endtask

	function automatic noise_item_t perm_load(logic [1:0] sel, logic [7:0] idx, logic [7:0] v);
		noise_item_t it;
		it = '{KIND_PERM, sel, idx, v, 16'(-1), 16'(-1), 16'(-1), '1, '1, '1};
		return it;
	endfunction

	function automatic noise_item_t grad_load(logic [7:0] idx, logic [15:0] x,
		logic [15:0] y, logic [15:0] z);
		noise_item_t it;
		it = '{KIND_GRAD, 2'($urandom), idx, 8'($urandom), x, y, z,
			$urandom, $urandom, $urandom};
		return it;
	endfunction

	function automatic noise_item_t eval_at(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		noise_item_t it;
		it = '{KIND_EVAL, 2'($urandom), 8'($urandom), 8'($urandom),
			16'($urandom), 16'($urandom), 16'($urandom), x, y, z};
		return it;
	endfunction

	function automatic logic [31:0] rand_pos();
		case ($urandom_range(0, 5))
			0: return 32'($signed($urandom_range(0, 'h7FFFF)) - 'h40000);
			1: return {$urandom_range(0, 1) ? 16'h7FFF : 16'h8000, 16'($urandom)};
			2: return {16'($urandom), $urandom_range(0, 1) ? 16'hFFFF : 16'h0000};
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] rand_grad();
		case ($urandom_range(0, 5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (noise_expect_q.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [3:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_OCTAVE_COUNT) octaves = data;
		else turb_on = data[0];
		@(posedge clk);
	endtask

	initial begin
		dir_rows[0]  = '{perm_load(2'd3, 8'd0, 8'hFF), 0, 0};
		dir_rows[1]  = '{eval_at(32'h0000_0000, 32'h0000_0000, 32'h0000_0000), 1, 21'sd0};
		dir_rows[2]  = '{eval_at(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1, 21'sd0};
		dir_rows[3]  = '{eval_at(32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1, 21'sd0};
		dir_rows[4]  = '{eval_at(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_FFFF), 1, 21'sd0};
		dir_rows[5]  = '{'{2'd3, 2'd3, 8'hFF, 8'hFF, '1, '1, '1, '1, '1, '1}, 0, 0};
		dir_rows[6]  = '{perm_load(SEL_X, 8'd0, 8'd0), 0, 0};
		dir_rows[7]  = '{perm_load(SEL_X, 8'd1, 8'd0), 0, 0};
		dir_rows[8]  = '{perm_load(SEL_Y, 8'd0, 8'd0), 0, 0};
		dir_rows[9]  = '{perm_load(SEL_Y, 8'd1, 8'd0), 0, 0};
		dir_rows[10] = '{perm_load(SEL_Z, 8'd0, 8'd0), 0, 0};
		dir_rows[11] = '{perm_load(SEL_Z, 8'hFF, 8'hFF), 0, 0};
		dir_rows[12] = '{grad_load(8'd0, 16'h7FFF, 16'h8000, 16'h7FFF), 0, 0};
		dir_rows[13] = '{grad_load(8'hFF, 16'h8000, 16'h8000, 16'h8000), 0, 0};
		dir_rows[14] = '{eval_at(32'h0000_8000, 32'h0000_8000, 32'h0000_8000), 0, 0};
		dir_rows[15] = '{eval_at(32'h0000_FFFF, 32'h0000_0001, 32'hFFFF_FFFF), 0, 0};
		dir_rows[16] = '{eval_at(32'h0000_0000, 32'h0000_0000, 32'hFFFF_8000), 0, 0};
		dir_rows[17] = '{eval_at(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_4000), 0, 0};
		dir_rows[18] = '{grad_load(8'd0, 16'h0000, 16'h0000, 16'h0000), 0, 0};
		dir_rows[19] = '{eval_at(32'h0000_8000, 32'h0000_8000, 32'h0000_8000), 0, 0};
	end

	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
			end else begin
				case (($urandom_range(0, 2)))
					0: begin
						m_tready <= 1'b1;
						repeat ($urandom_range(50, 400)) @(posedge clk);
					end
					1: repeat ($urandom_range(50, 400)) begin
						m_tready <= ($urandom_range(0, 3) != 0);
						@(posedge clk);
					end
					default: repeat ($urandom_range(20, 200)) begin
						m_tready <= ($urandom_range(0, 3) == 0);
						@(posedge clk);
					end
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (noise_expect_q.size() == 0) begin
				$display("%0t: unexpected result, actual %0d", $realtime,
					$signed(m_tdata[NOISE_W-1:0]));
				errors++;
			end else begin
				if (m_tdata[NOISE_W-1:0] !== noise_expect_q[0]) begin
					$display("%0t: noise_value expected %0d actual %0d", $realtime,
						noise_expect_q[0], $signed(m_tdata[NOISE_W-1:0]));
					errors++;
				end
				void'(noise_expect_q.pop_front());
			end
		end
	end

	initial begin
		#5_000_000;
		$display("gradient_noise_turbulence_top: mismatch");
		$finish;
	end

	initial begin
		logic [3:0] oct_set [7];
		logic       turb_set [7];
		int r;
		oct_set  = '{4'd7, 4'd1, 4'd8, 4'd15, 4'd0, 4'd3, 4'd5};
		turb_set = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
		errors = 0;
		results_seen = 0;
		evals_sent = 0;
		burst_left = 10;
		long_hold = 1'b0;
		octaves = OCTAVE_COUNT_RST;
		turb_on = TURB_MODE_RST;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all entries written first, gradients zero so early results are known
		for (int i = 0; i < 256; i++) begin
			send_item(perm_load(SEL_X, 8'(i), 8'($urandom)), 0, 0);
			send_item(perm_load(SEL_Y, 8'(i), 8'($urandom)), 0, 0);
			send_item(perm_load(SEL_Z, 8'(i), 8'($urandom)), 0, 0);
			send_item(grad_load(8'(i), 16'h0, 16'h0, 16'h0), 0, 0);
		end
		for (int i = 0; i < N_DIR; i++)
			send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].val);
		for (int i = 0; i < 256; i++)
			send_item(grad_load(8'(i), rand_grad(), rand_grad(), rand_grad()), 0, 0);

		for (int ph = 0; ph < 7; ph++) begin
			wait_drained();
			write_reg(REG_OCTAVE_COUNT, oct_set[ph]);
			write_reg(REG_TURBULENCE_MODE, {3'($urandom), turb_set[ph]});
			if (ph == 2) long_hold = 1'b1;
			for (int n = 0; n < 80; n++) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					send_item(eval_at(rand_pos(), rand_pos(), rand_pos()), 0, 0);
				else if (r < 88)
					send_item(perm_load(2'($urandom_range(0, 2)), 8'($urandom),
						8'($urandom)), 0, 0);
				else if (r < 97)
					send_item(grad_load(8'($urandom), rand_grad(), rand_grad(),
						rand_grad()), 0, 0);
				else
					send_item('{2'd3, 2'($urandom), 8'($urandom), 8'($urandom),
						16'($urandom), 16'($urandom), 16'($urandom),
						$urandom, $urandom, $urandom}, 0, 0);
			end
		end
		wait_drained();
		$display("Covered %0d point evaluations over 7 register settings, %0d results checked.",
			evals_sent, results_seen);
		$display("Tables fully loaded, ignored loads and kinds, and a long output stall included.");
		if (errors == 0 && noise_expect_q.size() == 0) begin
			$display("gradient_noise_turbulence_top: match");
		end else begin
			$display("gradient_noise_turbulence_top: mismatch");
		end
		$finish;
	end

endmodule

// ----- gradient_noise_turbulence_top.f -----
rtl/gnt_pkg.sv
rtl/gnt_ram.sv
rtl/gnt_corner.sv
rtl/gradient_noise_turbulence_top.sv
rtl/gnt_chk.sv
tb/sv/gradient_noise_turbulence_top_tb.sv
